// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Constants, register codes and helpers of the direct-mapped tag store.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int MAX_LINES_DEF = 16384;
    localparam int ADDR_BITS_DEF = 32;

    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int OFFSET_MIN = 4;
    localparam int OFFSET_MAX = 8;
    localparam int INDEX_MIN  = 4;
    localparam int INDEX_MAX  = 14;

    localparam int OFFSET_RST = 4;
    localparam int INDEX_RST  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_BITS = 2'd0,
        REG_INDEX_BITS  = 2'd1
    } t_cfg_reg;

    function automatic logic [CFG_DATA_W-1:0] clamp_field(
        input logic [CFG_DATA_W-1:0] v,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [CFG_DATA_W-1:0] r;
        priority if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/dmc_tag_store.sv =====
// ----------------------------------------------------------------------------
// dmc_tag_store
// Line memory holding a valid bit and a tag per line, with a clearing sweep
// and forwarding of a write to a read of the same line in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmc_tag_store
    import dmc_pkg::*;
#(
    parameter int LINE_BITS = $clog2(MAX_LINES_DEF),
    parameter int TAG_W     = ADDR_BITS_DEF - OFFSET_MIN - INDEX_MIN
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_rd_en,
    input  logic [LINE_BITS-1:0] i_rd_line,
    input  logic                 i_wr_en,
    input  logic [LINE_BITS-1:0] i_wr_line,
    input  logic [TAG_W-1:0]     i_wr_tag,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [TAG_W-1:0]     o_tag
);

    localparam int DEPTH = 2 ** LINE_BITS;

    logic [TAG_W:0]         r_mem [DEPTH];
    logic [TAG_W:0]         r_rd_data;
    logic                   r_fwd_en;
    logic [TAG_W-1:0]       r_fwd_tag;
    logic                   r_busy;
    logic [LINE_BITS-1:0]   r_clr_line;

    logic                   w_we;
    logic [LINE_BITS-1:0]   w_waddr;
    logic [TAG_W:0]         w_wdata;

    always_comb begin
        w_we    = r_busy || i_wr_en;
        w_waddr = r_busy ? r_clr_line : i_wr_line;
        w_wdata = r_busy ? '0 : {1'b1, i_wr_tag};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_line];
            r_fwd_tag <= i_wr_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_line <= '0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (i_clear) begin
                r_busy     <= 1'b1;
                r_clr_line <= '0;
                r_fwd_en   <= 1'b0;
            end else begin
                if (r_busy) begin
                    r_clr_line <= r_clr_line + 1'b1;
                    if (r_clr_line == {LINE_BITS{1'b1}}) begin
                        r_busy <= 1'b0;
                    end
                end
                if (i_rd_en) begin
                    r_fwd_en <= i_wr_en && (i_wr_line == i_rd_line);
                end
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_fwd_en || r_rd_data[TAG_W];
    assign o_tag   = r_fwd_en ? r_fwd_tag : r_rd_data[TAG_W-1:0];

    `ASSERT_IMPL(a_no_read_in_sweep, i_rd_en, !r_busy, "Line read during clearing sweep.")
    `ASSERT_IMPL(a_no_write_in_sweep, i_wr_en, !r_busy, "Line write during clearing sweep.")
    `ASSERT_IMPL(a_no_fwd_in_sweep, r_busy, !r_fwd_en, "Forwarding armed during clearing sweep.")

endmodule

// ===== rtl/direct_mapped_cache_hit_counter.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_counter
// Tag store of a direct-mapped cache with saturating hit and miss counters.
//
// Each input beat on s_axis carries one byte address. The address is split
// into offset, line index and tag by the offset_bits and index_bits registers.
// A valid line with a matching tag is a hit; otherwise the line takes the new
// tag. One result beat on m_axis follows each input beat, carrying the hit
// flag and both running totals, this access included.
// From input beat to result beat, an access passes the registered line memory
// read, then compare, write-back and the output register. One beat is taken per
// cycle while neither the clearing sweep nor a stall on m_axis holds the input; a
// write-back is forwarded to a read of the same line in the next beat.
// After reset, and after every write to a listed register, a clearing sweep
// walks the line memory one line per cycle, and both counters
// are zeroed; s_axis_tready stays low during the sweep. Writes on the
// configuration channel are always taken. When m_axis_tready is low the output
// register holds its beat, one more beat waits in the compare stage, and then
// s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module direct_mapped_cache_hit_counter
    import dmc_pkg::*;
#(
    parameter int MAX_LINES = MAX_LINES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte_address [31:0]
    input  logic [DATA_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hit [0], hit_total [32:1], miss_total [64:33], zero fill [71:65]
    output logic [71:0]           m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_BITS = $clog2(MAX_LINES);
    localparam int AW        = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
    localparam int TAG_W     = AW - OFFSET_MIN - INDEX_MIN;

    logic [CFG_DATA_W-1:0] r_offset_bits;
    logic [CFG_DATA_W-1:0] r_index_bits;
    logic                  r_s1_valid;
    logic [LINE_BITS-1:0]  r_s1_line;
    logic [TAG_W-1:0]      r_s1_tag;
    logic [COUNT_W-1:0]    r_hit_cnt;
    logic [COUNT_W-1:0]    r_miss_cnt;
    logic [COUNT_W-1:0]    n_hit_cnt;
    logic [COUNT_W-1:0]    n_miss_cnt;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [COUNT_W-1:0]    r_out_hit_total;
    logic [COUNT_W-1:0]    r_out_miss_total;

    logic                  w_cfg_clr;
    logic [CFG_DATA_W-1:0] w_ob;
    logic [CFG_DATA_W-1:0] w_ib;
    logic [4:0]            w_tag_sh;
    logic [DATA_W-1:0]     w_addr;
    logic [DATA_W-1:0]     w_block;
    logic [DATA_W-1:0]     w_tag_full;
    logic [LINE_BITS-1:0]  w_line_mask;
    logic [LINE_BITS-1:0]  w_line;
    logic                  w_in_acc;
    logic                  w_busy;
    logic                  w_ent_valid;
    logic [TAG_W-1:0]      w_ent_tag;
    logic                  w_hit;
    logic                  w_commit;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_clr   = i_cfg_valid &&
                         ((i_cfg_index == REG_OFFSET_BITS) || (i_cfg_index == REG_INDEX_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= CFG_DATA_W'(OFFSET_RST);
            r_index_bits  <= CFG_DATA_W'(INDEX_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                REG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ob        = clamp_field(r_offset_bits, CFG_DATA_W'(OFFSET_MIN),
                                  CFG_DATA_W'(OFFSET_MAX));
        w_ib        = clamp_field(r_index_bits, CFG_DATA_W'(INDEX_MIN),
                                  CFG_DATA_W'(INDEX_MAX));
        w_tag_sh    = {1'b0, w_ob} + {1'b0, w_ib};
        w_addr      = DATA_W'(s_axis_tdata[AW-1:0]);
        w_block     = w_addr >> w_ob;
        w_tag_full  = w_addr >> w_tag_sh;
        w_line_mask = ~({LINE_BITS{1'b1}} << w_ib);
        w_line      = w_block[LINE_BITS-1:0] & w_line_mask;
    end

    assign w_commit      = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !w_busy && (!r_s1_valid || w_commit);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_hit         = w_ent_valid && (w_ent_tag == r_s1_tag);

    dmc_tag_store #(
        .LINE_BITS (LINE_BITS),
        .TAG_W     (TAG_W)
    ) u_tag_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_cfg_clr),
        .i_rd_en   (w_in_acc),
        .i_rd_line (w_line),
        .i_wr_en   (w_commit && !w_hit),
        .i_wr_line (r_s1_line),
        .i_wr_tag  (r_s1_tag),
        .o_busy    (w_busy),
        .o_valid   (w_ent_valid),
        .o_tag     (w_ent_tag)
    );

    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_hit) begin
            if (r_hit_cnt != {COUNT_W{1'b1}}) begin
                n_hit_cnt = r_hit_cnt + 1'b1;
            end
        end else begin
            if (r_miss_cnt != {COUNT_W{1'b1}}) begin
                n_miss_cnt = r_miss_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_line <= w_line;
            r_s1_tag  <= w_tag_full[TAG_W-1:0];
        end
        if (w_commit) begin
            r_out_hit        <= w_hit;
            r_out_hit_total  <= n_hit_cnt;
            r_out_miss_total <= n_miss_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_commit) begin
                r_s1_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_clr) begin
                r_hit_cnt  <= '0;
                r_miss_cnt <= '0;
            end else if (w_commit) begin
                r_hit_cnt  <= n_hit_cnt;
                r_miss_cnt <= n_miss_cnt;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_miss_total, r_out_hit_total, r_out_hit};

    `ASSERT_IMPL(a_no_accept_in_sweep, w_in_acc, !w_busy, "Address taken during clearing sweep.")
    `ASSERT_NEXT(a_hit_count_step, w_commit && w_hit && !w_cfg_clr && (r_hit_cnt != '1), r_hit_cnt == $past(r_hit_cnt) + 1'b1, "Hit counter did not advance on a hit.")
    `ASSERT_IMPL(a_miss_count_mono, $past(i_rst_n) && !$past(w_cfg_clr), r_miss_cnt >= $past(r_miss_cnt), "Miss counter fell without a clear.")
    `ASSERT_NEXT(a_result_after_commit, w_commit, m_axis_tvalid, "Committed lookup left no result beat.")

endmodule
